/* src/cpft_pkg.sv */
// ----------------------------------------------------------------------------
// cpft_pkg
// Shared types for the critical path finish time block.
// ----------------------------------------------------------------------------
package cpft_pkg;

  localparam int unsigned TaskW = 11;
  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;

  typedef enum logic [1:0] {
    MODE_PRED    = 2'd0,
    MODE_CLOSE   = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [TaskW-1:0]  pred_task;
    logic [DurW-1:0]   duration;
  } cpft_req_t;

  typedef struct packed {
    logic [TaskW-1:0]  task_number;
    logic [TimeW-1:0]  finish_time;
    logic [TimeW-1:0]  overall_max;
    logic              bad_reference;
  } cpft_rsp_t;

endpackage

/* src/critical_path_finish_times_top.sv */
// ----------------------------------------------------------------------------
// critical_path_finish_times_top
// Earliest finish times of tasks arriving in topological order.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. Mode
//   PRED names one earlier task whose finish time joins the running max of
//   the current task; mode CLOSE adds the duration, stores the finish time as
//   the next task and returns one result unless the table is full; mode
//   RESTART begins a new job. One request per cycle is accepted, back to back
//   in any mode. A CLOSE result is registered after stage two and shown, with
//   result_valid high, for a single cycle. Requests are handled in two
//   stages: stage one issues the finish table read, stage two merges the
//   read data (or the value being written by a close right ahead of it) into
//   the state and writes the table. The single-port-read table sets this.
//   Reset clears the task counter and running values; busy is set while
//   reset is asserted and cleared once reset is low. Table contents are not
//   cleared: only entries of tasks closed in the current job are ever used.
//   The receiver cannot stall; each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module critical_path_finish_times_top
  import cpft_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 1024
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  cpft_req_t request,
  output logic      result_valid,
  output cpft_rsp_t result
);

  localparam int unsigned AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW   = $clog2(MAX_TASKS + 1);
  localparam int unsigned CMPW = (CW > TaskW) ? CW : TaskW;

  logic [TimeW-1:0] finish_table [MAX_TASKS];

  // stage one
  logic             s1_valid;
  cpft_req_t        s1_req;
  logic [AW-1:0]    rd_addr;
  logic [TimeW-1:0] rd_data;
  logic             fwd_hit;
  logic [TimeW-1:0] fwd_data;

  // job state
  logic [CW-1:0]    task_counter, task_counter_next;
  logic [TimeW-1:0] pred_max, pred_max_next;
  logic [TimeW-1:0] running_max, running_max_next;
  logic             bad_seen, bad_seen_next;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [TimeW-1:0] wr_data;
  logic             rsp_valid_next;
  cpft_rsp_t        rsp_next;

  logic             accept;
  logic [TaskW-1:0] pred_idx;
  logic [TimeW-1:0] pred_val;
  logic             pred_bad;
  logic [TimeW:0]   sum;
  logic [TimeW-1:0] fin;

  assign accept   = start && !busy;
  assign pred_idx = request.pred_task - TaskW'(1);

  always_comb begin
    if (AW > TaskW) rd_addr = AW'(pred_idx);
    else            rd_addr = pred_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      s1_valid <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_req   <= request;
    rd_data  <= finish_table[rd_addr];
    // a close in stage two writing the entry read now
    fwd_hit  <= wr_en && (wr_addr == rd_addr);
    fwd_data <= wr_data;
    if (wr_en) begin
      finish_table[wr_addr] <= wr_data;
    end
  end

  assign pred_val = fwd_hit ? fwd_data : rd_data;
  assign pred_bad = (s1_req.pred_task == '0) ||
                    (CMPW'(s1_req.pred_task) > CMPW'(task_counter));
  assign sum      = {1'b0, pred_max} + (TimeW + 1)'(s1_req.duration);
  assign fin      = sum[TimeW] ? '1 : sum[TimeW-1:0];
  assign wr_addr  = task_counter[AW-1:0];
  assign wr_data  = fin;

  always_comb begin
    task_counter_next = task_counter;
    pred_max_next     = pred_max;
    running_max_next  = running_max;
    bad_seen_next     = bad_seen;
    wr_en             = 1'b0;
    rsp_valid_next    = 1'b0;
    rsp_next          = result;
    if (s1_valid) begin
      case (s1_req.mode)
        MODE_PRED: begin
          if (pred_bad) begin
            bad_seen_next = 1'b1;
          end else if (pred_val > pred_max) begin
            pred_max_next = pred_val;
          end
        end
        MODE_CLOSE: begin
          pred_max_next = '0;
          bad_seen_next = 1'b0;
          if (CW'(MAX_TASKS) != task_counter) begin
            wr_en             = 1'b1;
            task_counter_next = task_counter + CW'(1);
            if (fin > running_max) running_max_next = fin;
            rsp_valid_next         = 1'b1;
            rsp_next.task_number   = TaskW'(task_counter_next);
            rsp_next.finish_time   = fin;
            rsp_next.overall_max   = (fin > running_max) ? fin : running_max;
            rsp_next.bad_reference = bad_seen;
          end
        end
        MODE_RESTART: begin
          task_counter_next = '0;
          pred_max_next     = '0;
          running_max_next  = '0;
          bad_seen_next     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      task_counter <= '0;
      pred_max     <= '0;
      running_max  <= '0;
      bad_seen     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      task_counter <= task_counter_next;
      pred_max     <= pred_max_next;
      running_max  <= running_max_next;
      bad_seen     <= bad_seen_next;
      result_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= rsp_next;
  end

`ifndef ASSERT_OFF
  a_rsp_from_close: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(s1_valid && (s1_req.mode == MODE_CLOSE)))
    else $error("result without a close request");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(task_counter) <= CMPW'(MAX_TASKS))
    else $error("task counter beyond table depth");

  a_max_covers: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.overall_max >= result.finish_time))
    else $error("overall max below finish time");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.task_number == TaskW'(task_counter)))
    else $error("task number does not match counter");
`endif

endmodule
